FILE: design/imu_attitude_remap_convert_top_macros.svh
// imu_attitude_remap_convert_top_macros.svh
// Assertion macros for the attitude remap block. Uses clk and rst_n of the including module.
`ifndef IMU_ATTITUDE_REMAP_CONVERT_TOP_MACROS_SVH
`define IMU_ATTITUDE_REMAP_CONVERT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define IMUARC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("imuarc: assertion failed");
`define IMUARC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imuarc: assertion failed");
`else
`define IMUARC_ASSERT(lbl, prop)
`define IMUARC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: design/imuarc_pkg.sv
// imuarc_pkg.sv
// Shared widths, Q30 constants, register codes and helper functions for the attitude remap.
// No dependencies.
package imuarc_pkg;

    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int QUAT_W    = 16;
    localparam int SEL_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int ROT_W     = 34;  // rotation CORDIC datapath
    localparam int SC_W      = 32;  // sine/cosine and first-order products
    localparam int QS_W      = 33;  // quaternion component sums
    localparam int Q_W       = 34;  // remapped components
    localparam int P_W       = 36;  // second-order products
    localparam int VEC_W     = 40;  // atan2 operands
    localparam int ANG_W     = 36;  // atan2 angle accumulator
    localparam int ANGR_W    = ANG_W + 1;
    localparam int SQ_W      = 61;  // square root radicand
    localparam int SQ_TOP    = 60;  // top bit weight of the radicand
    localparam int SQ_STEPS  = 31;  // one result bit per step
    localparam int SQRT_BITS = 31;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] GAIN_Q30    = 36'sd652032874;
    localparam logic signed [ANG_W-1:0] ONE_Q30     = 36'sd1073741824;
    localparam int QUAT_ONE = 16384;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 2'd3;

    // source component codes (selector magnitude)
    localparam logic [SEL_W:0] SRC_COMP_X = 5'd1;
    localparam logic [SEL_W:0] SRC_COMP_Y = 5'd2;
    localparam logic [SEL_W:0] SRC_COMP_Z = 5'd3;
    localparam logic [SEL_W:0] SRC_COMP_W = 5'd4;

    // atan(2^-i) in Q30
    function automatic logic signed [ANG_W-1:0] atan_step(input int i);
        logic signed [ANG_W-1:0] a;
        case (i)
            0:       a = 36'sd843314857;
            1:       a = 36'sd497837829;
            2:       a = 36'sd263043837;
            3:       a = 36'sd133525159;
            4:       a = 36'sd67021687;
            5:       a = 36'sd33543516;
            6:       a = 36'sd16775851;
            7:       a = 36'sd8388437;
            8:       a = 36'sd4194283;
            9:       a = 36'sd2097149;
            default: a = (i <= 30) ? (ANG_W'(1) <<< (30 - i)) : '0;
        endcase
        return a;
    endfunction

    // Q30 angle to w-bit output: round half up, then saturate
    function automatic logic signed [31:0] angle_round(input logic signed [ANG_W-1:0] z,
                                                       input int w);
        logic signed [ANGR_W-1:0] zr;
        logic signed [ANGR_W-1:0] r;
        logic signed [ANGR_W-1:0] hi;
        logic signed [ANGR_W-1:0] lo;
        zr = ANGR_W'(z) + (ANGR_W'(1) <<< (32 - w));
        r  = zr >>> (33 - w);
        hi = (ANGR_W'(1) <<< (w - 1)) - ANGR_W'(1);
        lo = -hi - ANGR_W'(1);
        if (r > hi)
            r = hi;
        if (r < lo)
            r = lo;
        return 32'(r);
    endfunction

endpackage

FILE: design/imuarc_cordic_rot.sv
// imuarc_cordic_rot.sv
// Pipelined rotation-mode CORDIC: sine and cosine of a Q30 half angle.
// Depends on imuarc_pkg.
module imuarc_cordic_rot #(
    parameter int STAGES = imuarc_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                    clk,
    input  logic                                    en,
    input  logic signed [imuarc_pkg::ROT_W-1:0]     h,
    output logic signed [imuarc_pkg::SC_W-1:0]      sin_val,
    output logic signed [imuarc_pkg::SC_W-1:0]      cos_val
);
    import imuarc_pkg::*;

    logic signed [ROT_W-1:0] x_reg [0:STAGES];
    logic signed [ROT_W-1:0] y_reg [0:STAGES];
    logic signed [ROT_W-1:0] z_reg [0:STAGES];
    logic                    flip_reg [0:STAGES];
    logic signed [SC_W-1:0]  sin_reg;
    logic signed [SC_W-1:0]  cos_reg;
    logic signed [ROT_W-1:0] z_fold;
    logic                    flip_fold;

    // fold beyond a quarter turn by reflection about +-pi/2
    always_comb
    begin
        z_fold    = h;
        flip_fold = 1'b0;
        if (h > HALF_PI_Q30)
        begin
            z_fold    = ROT_W'(PI_Q30 - h);
            flip_fold = 1'b1;
        end
        else if (h < -HALF_PI_Q30)
        begin
            z_fold    = ROT_W'(-PI_Q30 - h);
            flip_fold = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= ROT_W'(GAIN_Q30);
            y_reg[0]    <= '0;
            z_reg[0]    <= z_fold;
            flip_reg[0] <= flip_fold;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [ROT_W-1:0] ANG = ROT_W'(atan_step(i));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ANG;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ANG;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= SC_W'(y_reg[STAGES]);
            cos_reg <= flip_reg[STAGES] ? SC_W'(-x_reg[STAGES]) : SC_W'(x_reg[STAGES]);
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

FILE: design/imuarc_cordic_vec.sv
// imuarc_cordic_vec.sv
// Pipelined vectoring-mode CORDIC atan2, rounded and saturated to the output angle width.
// Depends on imuarc_pkg.
module imuarc_cordic_vec #(
    parameter int STAGES      = imuarc_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_WIDTH = imuarc_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    en,
    input  logic signed [imuarc_pkg::VEC_W-1:0]     y_in,
    input  logic signed [imuarc_pkg::VEC_W-1:0]     x_in,
    output logic signed [ANGLE_WIDTH-1:0]           angle
);
    import imuarc_pkg::*;

    logic signed [VEC_W-1:0]       x_reg [0:STAGES];
    logic signed [VEC_W-1:0]       y_reg [0:STAGES];
    logic signed [ANG_W-1:0]       z_reg [0:STAGES];
    logic                          zero_reg [0:STAGES];
    logic signed [ANGLE_WIDTH-1:0] angle_reg;
    logic signed [31:0]            ang_full;

    // left half-plane: start at +-pi and mirror the vector
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                z_reg[0] <= (y_in >= 0) ? PI_Q30 : -PI_Q30;
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [ANG_W-1:0] ANG = atan_step(i);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ANG;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ANG;
                end
            end
        end
    end

    assign ang_full = angle_round(z_reg[STAGES], ANGLE_WIDTH);

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= zero_reg[STAGES] ? '0 : ang_full[ANGLE_WIDTH-1:0];
    end

    assign angle = angle_reg;

endmodule

FILE: design/imu_attitude_remap_convert_top.sv
// imu_attitude_remap_convert_top.sv
// Euler to quaternion, component remap, and back to Euler angles.
// Depends on imuarc_pkg, imuarc_cordic_rot, imuarc_cordic_vec and the assertion macro header.
//
// Usage
//   Input channel (in_valid/in_ready) carries roll, pitch and yaw in radians,
//   signed with ANGLE_WIDTH-3 fraction bits. Output channel (out_valid/out_ready)
//   carries the remapped quaternion (Q1.14) and the Euler angles recovered from it.
//   One transfer out for every transfer in, in order.
//   The four source selectors are written through cfg_wr_en/cfg_addr/cfg_wdata;
//   the user writes them only while no transfer is in flight (the block does not enforce it).
//   Throughput: one transfer per cycle, sustained while the receiver takes each result.
//   The two CORDIC pipelines and the 31-step bit-per-stage square root that
//   feeds the pitch asin lie between the input transfer and out_valid.
//   Reset clears all valid bits and loads the selectors with x, y, z, w.
//   When the receiver stalls, the finished result waits in the output register
//   and the pipeline keeps accepting until its last stage also holds a result;
//   then in_ready drops and the whole pipeline holds.
`include "imu_attitude_remap_convert_top_macros.svh"

module imu_attitude_remap_convert_top #(
    parameter int ANGLE_WIDTH   = imuarc_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = imuarc_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [ANGLE_WIDTH-1:0]          roll_in,
    input  logic signed [ANGLE_WIDTH-1:0]          pitch_in,
    input  logic signed [ANGLE_WIDTH-1:0]          yaw_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [imuarc_pkg::QUAT_W-1:0]   quat_x,
    output logic signed [imuarc_pkg::QUAT_W-1:0]   quat_y,
    output logic signed [imuarc_pkg::QUAT_W-1:0]   quat_z,
    output logic signed [imuarc_pkg::QUAT_W-1:0]   quat_w,
    output logic signed [ANGLE_WIDTH-1:0]          roll_out,
    output logic signed [ANGLE_WIDTH-1:0]          pitch_out,
    output logic signed [ANGLE_WIDTH-1:0]          yaw_out,
    input  logic                                   cfg_wr_en,
    input  logic [imuarc_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [imuarc_pkg::SEL_W-1:0]           cfg_wdata
);
    import imuarc_pkg::*;

    localparam int IN_SH    = 33 - ANGLE_WIDTH;
    localparam int ROT_LAT  = CORDIC_STAGES + 2;
    localparam int VEC_LAT  = CORDIC_STAGES + 2;
    localparam int ST_F     = ROT_LAT + 4;
    localparam int PIPE_LEN = ROT_LAT + 6 + SQ_STEPS + VEC_LAT;
    localparam int QR_W     = Q_W + 1;

    localparam logic signed [31:0] PITCH_POS_FULL = angle_round(HALF_PI_Q30, ANGLE_WIDTH);
    localparam logic signed [31:0] PITCH_NEG_FULL = angle_round(-HALF_PI_Q30, ANGLE_WIDTH);
    localparam logic signed [ANGLE_WIDTH-1:0] PITCH_POS = PITCH_POS_FULL[ANGLE_WIDTH-1:0];
    localparam logic signed [ANGLE_WIDTH-1:0] PITCH_NEG = PITCH_NEG_FULL[ANGLE_WIDTH-1:0];
    localparam logic signed [QUAT_W-1:0] Q_ONE = QUAT_W'(QUAT_ONE);
    localparam logic [SQ_W-1:0] SQ_ONE = SQ_W'(1) << SQ_TOP;

    // operands, flags and the quaternion carried from the angle-forming stage to the atan2 units
    typedef struct packed {
        logic signed [VEC_W-1:0] roll_y;
        logic signed [VEC_W-1:0] roll_x;
        logic signed [VEC_W-1:0] yaw_y;
        logic signed [VEC_W-1:0] yaw_x;
        logic signed [VEC_W-1:0] t;
        logic                    clamp_pos;
        logic                    clamp_neg;
        logic [3:0][QUAT_W-1:0]  quat;
    } conv_side_t;

    typedef struct packed {
        logic                   clamp_pos;
        logic                   clamp_neg;
        logic [3:0][QUAT_W-1:0] quat;
    } out_side_t;

    function automatic logic signed [SC_W-1:0] mul_sc(input logic signed [SC_W-1:0] a,
                                                      input logic signed [SC_W-1:0] b);
        logic signed [2*SC_W-1:0] p;
        p = a * b + ((2*SC_W)'(1) <<< 29);
        return p[SC_W+29:30];
    endfunction

    function automatic logic signed [P_W-1:0] mul_q(input logic signed [Q_W-1:0] a,
                                                    input logic signed [Q_W-1:0] b);
        logic signed [2*Q_W-1:0] p;
        p = a * b + ((2*Q_W)'(1) <<< 29);
        return p[P_W+29:30];
    endfunction

    function automatic logic signed [Q_W-1:0] remap(input logic signed [SEL_W-1:0] sel,
                                                    input logic signed [QS_W-1:0] q0,
                                                    input logic signed [QS_W-1:0] q1,
                                                    input logic signed [QS_W-1:0] q2,
                                                    input logic signed [QS_W-1:0] q3);
        logic signed [SEL_W:0] sel_ext;
        logic [SEL_W:0]        mag;
        logic signed [Q_W-1:0] pick;
        sel_ext = (SEL_W+1)'(sel);
        mag     = (sel_ext < 0) ? -sel_ext : sel_ext;
        case (mag)
            SRC_COMP_X: pick = Q_W'(q0);
            SRC_COMP_Y: pick = Q_W'(q1);
            SRC_COMP_Z: pick = Q_W'(q2);
            SRC_COMP_W: pick = Q_W'(q3);
            default:    pick = '0;
        endcase
        return (sel_ext < 0) ? -pick : pick;
    endfunction

    function automatic logic signed [QUAT_W-1:0] quat_round(input logic signed [Q_W-1:0] r);
        logic signed [QR_W-1:0] s;
        s = (QR_W'(r) + (QR_W'(1) <<< 15)) >>> 16;
        if (s > QR_W'(QUAT_ONE))
            s = QR_W'(QUAT_ONE);
        if (s < -QR_W'(QUAT_ONE))
            s = -QR_W'(QUAT_ONE);
        return s[QUAT_W-1:0];
    endfunction

    // control
    logic [PIPE_LEN-1:0]     vld_reg;
    logic                    out_valid_reg;
    logic                    adv;
    logic signed [SEL_W-1:0] src_reg [0:3];

    // rotation CORDIC
    logic signed [ROT_W-1:0] h_in [0:2];
    logic signed [SC_W-1:0]  sn [0:2];
    logic signed [SC_W-1:0]  cs [0:2];

    // product stages
    logic signed [SC_W-1:0]  m1_reg [0:3];
    logic signed [SC_W-1:0]  sn2_reg;
    logic signed [SC_W-1:0]  cs2_reg;
    logic signed [SC_W-1:0]  m2_reg [0:7];
    logic signed [QS_W-1:0]  q_sum [0:3];
    logic signed [Q_W-1:0]   r_next [0:3];
    logic signed [Q_W-1:0]   r_reg [0:3];
    logic [3:0][QUAT_W-1:0]  qo_reg;
    logic [3:0][QUAT_W-1:0]  qo_p_reg;
    logic signed [P_W-1:0]   p_reg [0:8];
    conv_side_t              f_next;
    conv_side_t              f_reg;

    // pitch square root
    logic signed [SQRT_BITS-1:0] t_lo;
    logic signed [2*SQRT_BITS-1:0] t_sq;
    logic [SQ_W-1:0]         tt_reg;
    conv_side_t              tt_side_reg;
    logic [SQ_W-1:0]         rem_reg [0:SQ_STEPS-1];
    logic [SQ_W-1:0]         res_reg [0:SQ_STEPS-1];
    conv_side_t              sq_side_reg [0:SQ_STEPS-1];
    conv_side_t              sq_last;
    logic signed [VEC_W-1:0] sqrt_x;

    // atan2 and output
    out_side_t                     vs_reg [0:VEC_LAT-1];
    logic signed [ANGLE_WIDTH-1:0] roll_ang;
    logic signed [ANGLE_WIDTH-1:0] pitch_ang;
    logic signed [ANGLE_WIDTH-1:0] yaw_ang;
    logic signed [QUAT_W-1:0]      quat_x_reg;
    logic signed [QUAT_W-1:0]      quat_y_reg;
    logic signed [QUAT_W-1:0]      quat_z_reg;
    logic signed [QUAT_W-1:0]      quat_w_reg;
    logic signed [ANGLE_WIDTH-1:0] roll_out_reg;
    logic signed [ANGLE_WIDTH-1:0] pitch_out_reg;
    logic signed [ANGLE_WIDTH-1:0] yaw_out_reg;

    // Whole pipeline moves together; it holds only when the last stage and the
    // output register both carry a result and the receiver is not taking one.
    assign adv      = !(vld_reg[PIPE_LEN-1] && out_valid_reg && !out_ready);
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                vld_reg <= {vld_reg[PIPE_LEN-2:0], in_valid};
            if (adv && vld_reg[PIPE_LEN-1])
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // source selectors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg[REG_SRC_X] <= SEL_W'(SRC_COMP_X);
            src_reg[REG_SRC_Y] <= SEL_W'(SRC_COMP_Y);
            src_reg[REG_SRC_Z] <= SEL_W'(SRC_COMP_Z);
            src_reg[REG_SRC_W] <= SEL_W'(SRC_COMP_W);
        end
        else if (cfg_wr_en)
        begin
            src_reg[cfg_addr] <= cfg_wdata;
        end
    end

    // half angles in Q30
    always_comb
    begin
        h_in[0] = (ROT_W'(roll_in) <<< IN_SH) >>> 1;
        h_in[1] = (ROT_W'(pitch_in) <<< IN_SH) >>> 1;
        h_in[2] = (ROT_W'(yaw_in) <<< IN_SH) >>> 1;
    end

    for (genvar k = 0; k < 3; k++) begin : g_rot
        imuarc_cordic_rot #(
            .STAGES (CORDIC_STAGES)
        ) u_rot (
            .clk     (clk),
            .en      (adv),
            .h       (h_in[k]),
            .sin_val (sn[k]),
            .cos_val (cs[k])
        );
    end

    // quaternion components and remap
    always_comb
    begin
        q_sum[0] = QS_W'(m2_reg[0]) - QS_W'(m2_reg[1]);
        q_sum[1] = QS_W'(m2_reg[2]) + QS_W'(m2_reg[3]);
        q_sum[2] = QS_W'(m2_reg[4]) - QS_W'(m2_reg[5]);
        q_sum[3] = QS_W'(m2_reg[6]) + QS_W'(m2_reg[7]);
        for (int k = 0; k < 4; k++)
            r_next[k] = remap(src_reg[k], q_sum[0], q_sum[1], q_sum[2], q_sum[3]);
    end

    // r_reg: 0 = x, 1 = y, 2 = z, 3 = w
    always_comb
    begin
        f_next.roll_y    = (VEC_W'(p_reg[0]) + VEC_W'(p_reg[1])) <<< 1;
        f_next.roll_x    = VEC_W'(ONE_Q30) - ((VEC_W'(p_reg[2]) + VEC_W'(p_reg[3])) <<< 1);
        f_next.t         = (VEC_W'(p_reg[4]) - VEC_W'(p_reg[5])) <<< 1;
        f_next.yaw_y     = (VEC_W'(p_reg[6]) + VEC_W'(p_reg[7])) <<< 1;
        f_next.yaw_x     = VEC_W'(ONE_Q30) - ((VEC_W'(p_reg[3]) + VEC_W'(p_reg[8])) <<< 1);
        f_next.clamp_pos = f_next.t >= VEC_W'(ONE_Q30);
        f_next.clamp_neg = f_next.t <= -VEC_W'(ONE_Q30);
        f_next.quat      = qo_p_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // first-order products
            m1_reg[0] <= mul_sc(sn[0], cs[1]);
            m1_reg[1] <= mul_sc(cs[0], sn[1]);
            m1_reg[2] <= mul_sc(cs[0], cs[1]);
            m1_reg[3] <= mul_sc(sn[0], sn[1]);
            sn2_reg   <= sn[2];
            cs2_reg   <= cs[2];
            // second-order products
            m2_reg[0] <= mul_sc(m1_reg[0], cs2_reg);
            m2_reg[1] <= mul_sc(m1_reg[1], sn2_reg);
            m2_reg[2] <= mul_sc(m1_reg[1], cs2_reg);
            m2_reg[3] <= mul_sc(m1_reg[0], sn2_reg);
            m2_reg[4] <= mul_sc(m1_reg[2], sn2_reg);
            m2_reg[5] <= mul_sc(m1_reg[3], cs2_reg);
            m2_reg[6] <= mul_sc(m1_reg[2], cs2_reg);
            m2_reg[7] <= mul_sc(m1_reg[3], sn2_reg);
            // remapped components
            for (int k = 0; k < 4; k++)
            begin
                r_reg[k]  <= r_next[k];
                qo_reg[k] <= quat_round(r_next[k]);
            end
            // component products
            p_reg[0] <= mul_q(r_reg[3], r_reg[0]);
            p_reg[1] <= mul_q(r_reg[1], r_reg[2]);
            p_reg[2] <= mul_q(r_reg[0], r_reg[0]);
            p_reg[3] <= mul_q(r_reg[1], r_reg[1]);
            p_reg[4] <= mul_q(r_reg[3], r_reg[1]);
            p_reg[5] <= mul_q(r_reg[2], r_reg[0]);
            p_reg[6] <= mul_q(r_reg[3], r_reg[2]);
            p_reg[7] <= mul_q(r_reg[0], r_reg[1]);
            p_reg[8] <= mul_q(r_reg[2], r_reg[2]);
            qo_p_reg <= qo_reg;
            // atan2 operands
            f_reg <= f_next;
            // sinp squared; only meaningful when |sinp| < 1
            tt_reg      <= t_sq[SQ_W-1:0];
            tt_side_reg <= f_reg;
        end
    end

    assign t_lo = f_reg.t[SQRT_BITS-1:0];
    assign t_sq = t_lo * t_lo;

    // sqrt(1 - sinp^2), one result bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_TOP - 2*k);
        logic [SQ_W-1:0] rem_in;
        logic [SQ_W-1:0] res_in;
        conv_side_t      side_in;
        logic [SQ_W:0]   trial;
        if (k == 0) begin : g_first
            assign rem_in  = SQ_ONE - tt_reg;
            assign res_in  = '0;
            assign side_in = tt_side_reg;
        end
        else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign res_in  = res_reg[k-1];
            assign side_in = sq_side_reg[k-1];
        end
        assign trial = {1'b0, res_in} + {1'b0, BIT};
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_side_reg[k] <= side_in;
                if ({1'b0, rem_in} >= trial)
                begin
                    rem_reg[k] <= rem_in - trial[SQ_W-1:0];
                    res_reg[k] <= (res_in >> 1) + BIT;
                end
                else
                begin
                    rem_reg[k] <= rem_in;
                    res_reg[k] <= res_in >> 1;
                end
            end
        end
    end

    assign sq_last = sq_side_reg[SQ_STEPS-1];
    assign sqrt_x  = $signed({{(VEC_W-SQRT_BITS){1'b0}}, res_reg[SQ_STEPS-1][SQRT_BITS-1:0]});

    imuarc_cordic_vec #(
        .STAGES      (CORDIC_STAGES),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_roll (
        .clk   (clk),
        .en    (adv),
        .y_in  (sq_last.roll_y),
        .x_in  (sq_last.roll_x),
        .angle (roll_ang)
    );

    imuarc_cordic_vec #(
        .STAGES      (CORDIC_STAGES),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_pitch (
        .clk   (clk),
        .en    (adv),
        .y_in  (sq_last.t),
        .x_in  (sqrt_x),
        .angle (pitch_ang)
    );

    imuarc_cordic_vec #(
        .STAGES      (CORDIC_STAGES),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_yaw (
        .clk   (clk),
        .en    (adv),
        .y_in  (sq_last.yaw_y),
        .x_in  (sq_last.yaw_x),
        .angle (yaw_ang)
    );

    // quaternion and pitch clamp travel alongside the atan2 units
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vs_reg[0].clamp_pos <= sq_last.clamp_pos;
            vs_reg[0].clamp_neg <= sq_last.clamp_neg;
            vs_reg[0].quat      <= sq_last.quat;
            for (int k = 1; k < VEC_LAT; k++)
                vs_reg[k] <= vs_reg[k-1];
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (adv && vld_reg[PIPE_LEN-1])
        begin
            quat_x_reg   <= vs_reg[VEC_LAT-1].quat[0];
            quat_y_reg   <= vs_reg[VEC_LAT-1].quat[1];
            quat_z_reg   <= vs_reg[VEC_LAT-1].quat[2];
            quat_w_reg   <= vs_reg[VEC_LAT-1].quat[3];
            roll_out_reg <= roll_ang;
            yaw_out_reg  <= yaw_ang;
            if (vs_reg[VEC_LAT-1].clamp_pos)
                pitch_out_reg <= PITCH_POS;
            else if (vs_reg[VEC_LAT-1].clamp_neg)
                pitch_out_reg <= PITCH_NEG;
            else
                pitch_out_reg <= pitch_ang;
        end
    end

    assign out_valid = out_valid_reg;
    assign quat_x    = quat_x_reg;
    assign quat_y    = quat_y_reg;
    assign quat_z    = quat_z_reg;
    assign quat_w    = quat_w_reg;
    assign roll_out  = roll_out_reg;
    assign pitch_out = pitch_out_reg;
    assign yaw_out   = yaw_out_reg;

    // a result leaving the last stage always lands in the output register
    `IMUARC_ASSERT_NEXT(a_load_shows, adv && vld_reg[PIPE_LEN-1], out_valid)
    // clamp directions never both set
    `IMUARC_ASSERT(a_clamp_excl, !(vld_reg[ST_F] && f_reg.clamp_pos && f_reg.clamp_neg))
    // out-of-range sinp gives +-pi/2
    `IMUARC_ASSERT_NEXT(a_pitch_pos,
        adv && vld_reg[PIPE_LEN-1] && vs_reg[VEC_LAT-1].clamp_pos, pitch_out == PITCH_POS)
    `IMUARC_ASSERT_NEXT(a_pitch_neg,
        adv && vld_reg[PIPE_LEN-1] && vs_reg[VEC_LAT-1].clamp_neg, pitch_out == PITCH_NEG)
    // quat_x output stays within plus or minus one while out_valid is high
    `IMUARC_ASSERT(a_quat_range, !out_valid || (quat_x <= Q_ONE && quat_x >= -Q_ONE))

endmodule
